FILE: hdl/npcs_pkg.sv
// Shared widths, codes and state type for the nearest palette color search block.
package npcs_pkg;

    localparam int INDEX_W = 8;
    localparam int COLOR_W = 16;
    localparam int CHAN_W  = 8;
    localparam int SQ_W    = 2 * CHAN_W;
    // Three squared 8-bit differences sum to at most 195075, which needs 18 bits.
    localparam int DIST_W  = SQ_W + 2;

    // RGB565 field positions.
    localparam int RED_LSB   = 11;
    localparam int RED_W     = 5;
    localparam int GREEN_LSB = 5;
    localparam int GREEN_W   = 6;
    localparam int BLUE_LSB  = 0;
    localparam int BLUE_W    = 5;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_HOLD = 3'b100
    } state_t;

endpackage

FILE: hdl/nearest_palette_color_search.sv
// Nearest palette color search: palette memory, scan pipeline and result register.
//
//   channel  direction  ports                                   item
//   s_       in         s_valid s_ready s_action ... s_query_*  palette write or query
//   m_       out        m_valid m_ready m_best_index            chosen palette index
//
// A write item is taken and gives no result. A query walks the palette
// one entry a cycle through a four-stage distance pipeline (memory read, absolute
// difference, square, sum and compare), and an exact match ends the walk early.
// s_ready is high only between queries.
// Reset marks every palette entry as zero through per-entry valid bits; no clearing pass.
// A result that is not taken holds the next query's finish until the output frees.
module nearest_palette_color_search #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_action,
    input  logic [npcs_pkg::INDEX_W-1:0]  s_entry_index,
    input  logic [npcs_pkg::COLOR_W-1:0]  s_entry_color,
    input  logic [npcs_pkg::CHAN_W-1:0]   s_query_red,
    input  logic [npcs_pkg::CHAN_W-1:0]   s_query_green,
    input  logic [npcs_pkg::CHAN_W-1:0]   s_query_blue,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [npcs_pkg::INDEX_W-1:0]  m_best_index
);
    import npcs_pkg::*;

    localparam int IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(PALETTE_ENTRIES - 1);
    localparam logic [INDEX_W:0] ENTRY_LIMIT = (INDEX_W + 1)'(PALETTE_ENTRIES);

    logic [COLOR_W-1:0] palette_mem [PALETTE_ENTRIES];
    logic [PALETTE_ENTRIES-1:0] entry_vld_reg;

    state_t state_reg, state_next;
    logic   issue_reg, issue_next;
    logic [IDX_W-1:0] scan_addr_reg, scan_addr_next;

    logic [CHAN_W-1:0] qr_reg, qg_reg, qb_reg;

    // Stage A: registered memory read.
    logic               a_vld_reg, a_vld_next;
    logic               a_last_reg;
    logic [IDX_W-1:0]   a_idx_reg;
    logic [COLOR_W-1:0] rd_data_reg;
    logic               rd_ok_reg;

    // Stage B: absolute channel differences.
    logic              b_vld_reg, b_vld_next;
    logic              b_last_reg;
    logic [IDX_W-1:0]  b_idx_reg;
    logic [CHAN_W-1:0] dr_reg, dg_reg, db_reg;

    // Stage C: squared differences.
    logic              c_vld_reg, c_vld_next;
    logic              c_last_reg;
    logic [IDX_W-1:0]  c_idx_reg;
    logic [SQ_W-1:0]   sr_reg, sg_reg, sb_reg;

    // Stage D: running best.
    logic              have_reg, have_next;
    logic [DIST_W-1:0] best_dist_reg, best_dist_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;

    logic               m_valid_reg, m_valid_next;
    logic [INDEX_W-1:0] m_best_reg, m_best_next;

    logic s_fire;
    logic wr_en;
    logic [COLOR_W-1:0] entry_word;
    logic [CHAN_W-1:0]  er, eg, eb;
    logic [DIST_W-1:0]  cand_dist;
    logic               take;
    logic               finish;

    assign s_ready      = (state_reg == ST_IDLE);
    assign s_fire       = s_valid && s_ready;
    assign wr_en        = s_fire && (s_action == ACT_WRITE)
                          && ({1'b0, s_entry_index} < ENTRY_LIMIT);
    assign m_valid      = m_valid_reg;
    assign m_best_index = m_best_reg;

    // An entry never written since reset reads as black.
    assign entry_word = rd_ok_reg ? rd_data_reg : '0;
    assign er = CHAN_W'(entry_word[RED_LSB +: RED_W]);
    assign eg = CHAN_W'(entry_word[GREEN_LSB +: GREEN_W]);
    assign eb = CHAN_W'(entry_word[BLUE_LSB +: BLUE_W]);

    assign cand_dist = DIST_W'(sr_reg) + DIST_W'(sg_reg) + DIST_W'(sb_reg);
    assign take      = c_vld_reg && (!have_reg || (cand_dist < best_dist_reg));
    // A zero distance cannot be beaten, so the walk may end there.
    assign finish = (state_reg == ST_SCAN) && c_vld_reg && (c_last_reg || (cand_dist == '0));

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            palette_mem[s_entry_index[IDX_W-1:0]] <= s_entry_color;
        end
        rd_data_reg <= palette_mem[scan_addr_reg];
    end

    always_comb begin
        state_next     = state_reg;
        issue_next     = issue_reg;
        scan_addr_next = scan_addr_reg;
        a_vld_next     = 1'b0;
        b_vld_next     = a_vld_reg;
        c_vld_next     = b_vld_reg;
        have_next      = have_reg;
        best_dist_next = best_dist_reg;
        best_idx_next  = best_idx_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_best_next    = m_best_reg;

        if (take) begin
            have_next      = 1'b1;
            best_dist_next = cand_dist;
            best_idx_next  = c_idx_reg;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_fire && (s_action == ACT_QUERY)) begin
                    state_next     = ST_SCAN;
                    issue_next     = 1'b1;
                    scan_addr_next = '0;
                    have_next      = 1'b0;
                end
            end
            ST_SCAN: begin
                if (issue_reg) begin
                    a_vld_next = 1'b1;
                    if (scan_addr_reg == LAST_ADDR) begin
                        issue_next = 1'b0;
                    end else begin
                        scan_addr_next = scan_addr_reg + 1'b1;
                    end
                end
                if (finish) begin
                    // Drop any entries still in flight behind the deciding one.
                    state_next = ST_HOLD;
                    issue_next = 1'b0;
                    a_vld_next = 1'b0;
                    b_vld_next = 1'b0;
                    c_vld_next = 1'b0;
                end
            end
            ST_HOLD: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_best_next  = INDEX_W'(best_idx_reg);
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
                issue_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            issue_reg     <= 1'b0;
            a_vld_reg     <= 1'b0;
            b_vld_reg     <= 1'b0;
            c_vld_reg     <= 1'b0;
            have_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
            entry_vld_reg <= '0;
        end else begin
            state_reg   <= state_next;
            issue_reg   <= issue_next;
            a_vld_reg   <= a_vld_next;
            b_vld_reg   <= b_vld_next;
            c_vld_reg   <= c_vld_next;
            have_reg    <= have_next;
            m_valid_reg <= m_valid_next;
            if (wr_en) begin
                entry_vld_reg[s_entry_index[IDX_W-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        scan_addr_reg <= scan_addr_next;
        best_dist_reg <= best_dist_next;
        best_idx_reg  <= best_idx_next;
        m_best_reg    <= m_best_next;

        if (s_fire && (s_action == ACT_QUERY)) begin
            qr_reg <= s_query_red;
            qg_reg <= s_query_green;
            qb_reg <= s_query_blue;
        end

        a_idx_reg  <= scan_addr_reg;
        a_last_reg <= (scan_addr_reg == LAST_ADDR);
        rd_ok_reg  <= entry_vld_reg[scan_addr_reg];

        b_idx_reg  <= a_idx_reg;
        b_last_reg <= a_last_reg;
        dr_reg     <= (qr_reg >= er) ? (qr_reg - er) : (er - qr_reg);
        dg_reg     <= (qg_reg >= eg) ? (qg_reg - eg) : (eg - qg_reg);
        db_reg     <= (qb_reg >= eb) ? (qb_reg - eb) : (eb - qb_reg);

        c_idx_reg  <= b_idx_reg;
        c_last_reg <= b_last_reg;
        sr_reg     <= SQ_W'(dr_reg) * SQ_W'(dr_reg);
        sg_reg     <= SQ_W'(dg_reg) * SQ_W'(dg_reg);
        sb_reg     <= SQ_W'(db_reg) * SQ_W'(db_reg);
    end

endmodule
